// ===== src/kft_pkg.sv =====
// Shared types and constants for the key frequency table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package kft_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int REMOVED_W   = 9;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - REMOVED_W - COUNT_W;

    localparam logic [ACTION_W-1:0] ACT_INCR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PRUNE  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic accept;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic stop;
        logic scan_op;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/kft_ctrl.sv =====
// Controller state machine for the key frequency table.
// Depends on kft_pkg; drives the datapath through t_cmd and reads t_stat.
`default_nettype none

module kft_ctrl import kft_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = i_stat.scan_op ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_stat.last || i_stat.stop) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_START: begin
                o_cmd.start = 1'b1;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/kft_dp.sv =====
// Datapath of the key frequency table: entry memory, scan pointer and result register.
// Depends on kft_pkg; sequenced by kft_ctrl through t_cmd.
`default_nettype none

module kft_dp import kft_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int KEY_BITS      = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [ACTION_W-1:0]  i_action,
    input  wire logic [WORD_W-1:0]    i_word_key,
    input  wire logic [COUNT_W-1:0]   i_threshold,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic [COUNT_W-1:0]        o_count,
    output logic [REMOVED_W-1:0]      o_removed
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int MW = 1 + KEY_BITS + COUNT_W;

    // Entry word: valid on top, then key, count in the low bits.
    logic [MW-1:0] r_mem [TABLE_ENTRIES];
    logic [MW-1:0] r_rd_data;

    logic [ACTION_W-1:0]  r_action;
    logic [KEY_BITS-1:0]  r_key;
    logic [COUNT_W-1:0]   r_thr;
    logic [IW-1:0]        r_ev_idx;
    logic                 r_found;
    logic [IW-1:0]        r_found_idx;
    logic [COUNT_W-1:0]   r_found_cnt;
    logic                 r_free;
    logic [IW-1:0]        r_free_idx;
    logic [REMOVED_W-1:0] r_removed;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [COUNT_W-1:0]   r_out_count;
    logic [REMOVED_W-1:0] r_out_removed;

    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [COUNT_W-1:0]   rd_count;
    logic                 is_prune;
    logic                 is_find;
    logic                 hit;
    logic                 prune_hit;
    logic                 last;
    logic [COUNT_W-1:0]   inc_cnt;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [MW-1:0]        wr_data;
    logic [STATUS_W-1:0]  n_out_status;
    logic [COUNT_W-1:0]   n_out_count;
    logic [REMOVED_W-1:0] n_out_removed;

    assign rd_valid  = r_rd_data[MW-1];
    assign rd_key    = r_rd_data[COUNT_W +: KEY_BITS];
    assign rd_count  = r_rd_data[COUNT_W-1:0];
    assign is_prune  = (r_action == ACT_PRUNE);
    assign is_find   = (r_action == ACT_INCR) || (r_action == ACT_LOOKUP);
    assign hit       = rd_valid && (rd_key == r_key);
    assign prune_hit = rd_valid && (rd_count < r_thr);
    assign last      = (r_ev_idx == IW'(TABLE_ENTRIES - 1));
    assign inc_cnt   = (r_found_cnt == '1) ? r_found_cnt : r_found_cnt + COUNT_W'(1);

    assign o_stat.last     = last;
    assign o_stat.stop     = hit && is_find;
    assign o_stat.scan_op  = is_find || is_prune;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // The read for entry k+1 goes out while entry k is being evaluated.
    assign rd_addr = (i_cmd.start || last) ? '0 : r_ev_idx + IW'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_idx;
        wr_data = {1'b0, rd_key, rd_count};
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end else if (i_cmd.step && is_prune && prune_hit) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && r_action == ACT_INCR) begin
            if (r_found) begin
                wr_en   = 1'b1;
                wr_addr = r_found_idx;
                wr_data = {1'b1, r_key, inc_cnt};
            end else if (r_free) begin
                wr_en   = 1'b1;
                wr_addr = r_free_idx;
                wr_data = {1'b1, r_key, COUNT_W'(1)};
            end
        end
    end

    always_comb begin
        n_out_status  = STAT_OK;
        n_out_count   = '0;
        n_out_removed = '0;
        case (r_action)
            ACT_INCR: begin
                if (r_found) begin
                    n_out_count = inc_cnt;
                end else if (r_free) begin
                    n_out_count = COUNT_W'(1);
                end else begin
                    n_out_status = STAT_FULL;
                end
            end
            ACT_LOOKUP: begin
                if (r_found) begin
                    n_out_count = r_found_cnt;
                end else begin
                    n_out_status = STAT_ABSENT;
                end
            end
            ACT_PRUNE: begin
                n_out_removed = r_removed;
            end
            default: begin
                n_out_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_idx    <= '0;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ev_idx  <= '0;
                r_found   <= 1'b0;
                r_free    <= 1'b0;
                r_removed <= '0;
            end else if (i_cmd.clr || i_cmd.step) begin
                r_ev_idx <= last ? '0 : r_ev_idx + IW'(1);
            end
            if (i_cmd.step) begin
                if (is_find && hit) begin
                    r_found <= 1'b1;
                end
                if (!rd_valid && !r_free) begin
                    r_free <= 1'b1;
                end
                if (is_prune && prune_hit && r_removed != '1) begin
                    r_removed <= r_removed + REMOVED_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_key    <= KEY_BITS'(i_word_key);
            r_thr    <= i_threshold;
        end
        if (i_cmd.step) begin
            if (is_find && hit) begin
                r_found_idx <= r_ev_idx;
                r_found_cnt <= rd_count;
            end
            if (!rd_valid && !r_free) begin
                r_free_idx <= r_ev_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out_status  <= n_out_status;
            r_out_count   <= n_out_count;
            r_out_removed <= n_out_removed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_removed   = r_out_removed;

    // A new result is only loaded once the previous one has left.
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending word");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.finish))
        else $error("output valid rose without a finish");

    a_found_not_prune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_cmd.accept) |-> !is_prune)
        else $error("key match recorded during a prune");

    a_accept_clears_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_ev_idx == '0 && !r_found && !r_free && r_removed == '0))
        else $error("scan state not cleared on accept");

endmodule

`default_nettype wire

// ===== src/key_frequency_table_with_prune.sv =====
// Top level of the key frequency table with threshold prune.
// Depends on kft_pkg, kft_ctrl and kft_dp.
//
// Channel  Direction  tdata (low bit up)                 tuser
// s        in         word_key[31:0], threshold[63:32]   action[1:0]
// m        out        count[31:0], removed[40:32], zero  status[1:0]
//
// After reset a clearing pass marks every entry free; no word is accepted
// during it.
// Increment and lookup scan the entry memory one entry per cycle through its
// single read port and stop at a matching key. Prune scans every entry; an
// unknown action does not scan.
// One word is in work at a time; the next is accepted while a result waits.
// A stalled output only holds the finishing step until the result register frees.
`default_nettype none

module key_frequency_table_with_prune import kft_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int KEY_BITS      = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // word_key, threshold
    input  wire logic [ACTION_W-1:0]    i_s_tuser,   // action
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // count, removed, zero pad
    output logic [STATUS_W-1:0]         o_m_tuser    // status
);

    t_cmd                 cmd;
    t_stat                stat;
    logic [COUNT_W-1:0]   out_count;
    logic [REMOVED_W-1:0] out_removed;

    kft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kft_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_s_tuser),
        .i_word_key  (i_s_tdata[WORD_W-1:0]),
        .i_threshold (i_s_tdata[WORD_W +: COUNT_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_status    (o_m_tuser),
        .o_count     (out_count),
        .o_removed   (out_removed)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, out_removed, out_count};

endmodule

`default_nettype wire
